FILE: hw/rtl/mwdds_pkg.sv
// Shared types, codes and constants for the multi-waveform tone generator.
// Holds the rounding helper for the elaboration-time quarter-wave sine table.
// No dependencies.
package mwdds_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY       = 2'd3;

	// Field and register widths
	localparam int CFG_DATA_W = 32;
	localparam int STEP_W     = 32;
	localparam int MODE_W     = 3;
	localparam int AMP_W      = 15;
	localparam int DUTY_W     = 17;
	localparam int U_W        = 16;   // phase bits that select the shape
	localparam int MAG_W      = 17;   // shape magnitude, up to 65536
	localparam int SHAPE_W    = 18;   // signed shape, -65536..65536
	localparam int PROD_W     = AMP_W + MAG_W;
	localparam int SAMPLE_W   = 16;

	// Waveform codes
	localparam logic [MODE_W-1:0] MODE_SINE     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_RAMP     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SAWTOOTH = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SQUARE   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_TRIANGLE = 3'd4;

	localparam logic [DUTY_W-1:0] DUTY_RESET = 17'd32768;

	// pi/2 in Q30
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Shape handed from the shape stage to the scaling stage
	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
	} shape_t;

	// Clamp a Q30 Taylor sum at zero and round it to Q16; elaboration only
	function automatic logic [MAG_W-1:0] sine_round_q16(input longint sum);
		longint      clamped;
		logic [63:0] scaled;
		clamped = sum;
		if (clamped < 0) begin
			clamped = 0;
		end
		scaled = (64'(clamped) * 64'd65536 + (64'd1 << 29)) >> 30;
		return scaled[MAG_W-1:0];
	endfunction

endpackage

FILE: hw/rtl/mwdds_phase.sv
// Phase accumulator and first pipeline stage of the tone generator.
// Captures the top phase bits of each sample transaction, then steps or loads the phase.
// Depends on mwdds_pkg.
module mwdds_phase #(
	parameter int PHASE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  logic                          func,
	input  logic [31:0]                   phase_value,
	input  logic [mwdds_pkg::STEP_W-1:0]  phase_step,
	output logic                          valid_s1,
	output logic [mwdds_pkg::U_W-1:0]     u_s1,
	input  logic                          ready_s2
);
	import mwdds_pkg::*;

	logic [PHASE_BITS-1:0]    phase_q;
	logic [PHASE_BITS+31:0]   load_ext;
	logic [PHASE_BITS+31:0]   step_ext;
	logic                     ready_s1;
	logic                     accept;

	// Stage 1 takes a new transaction when empty or when it drains this cycle
	assign ready_s1  = !valid_s1 || ready_s2;
	assign cmd_stall = !ready_s1;
	assign accept    = cmd_valid && ready_s1;

	// Fit the 32-bit load value and step to the accumulator width
	assign load_ext = {{PHASE_BITS{1'b0}}, phase_value};
	assign step_ext = {{PHASE_BITS{1'b0}}, phase_step};

	// Load or advance the phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (accept) begin
			if (func) begin
				phase_q <= load_ext[PHASE_BITS-1:0];
			end else begin
				phase_q <= phase_q + step_ext[PHASE_BITS-1:0];
			end
		end
	end

	// Hold stage 1 valid; only sample transactions enter the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= cmd_valid && !func;
		end
	end

	// Capture the phase in effect before the step
	always_ff @(posedge clk) begin
		if (accept && !func) begin
			u_s1 <= phase_q[PHASE_BITS-1 -: U_W];
		end
	end

endmodule

FILE: hw/rtl/mwdds_shape.sv
// Shape stage of the tone generator: quarter-wave sine ROM and the piecewise-linear shapes.
// Produces sign and magnitude of the shape value in units of 2^-16.
// Depends on mwdds_pkg.
module mwdds_shape #(
	parameter int SINE_TABLE_ADDR_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s1,
	input  logic [mwdds_pkg::U_W-1:0]     u_s1,
	output logic                          ready_s2,
	input  logic [mwdds_pkg::MODE_W-1:0]  waveform_mode,
	input  logic [mwdds_pkg::DUTY_W-1:0]  duty_threshold,
	output logic                          valid_s2,
	output mwdds_pkg::shape_t             shape_s2,
	input  logic                          ready_s3
);
	import mwdds_pkg::*;

	localparam int SINE_N = 1 << SINE_TABLE_ADDR_BITS;
	localparam int ADDR_W = SINE_TABLE_ADDR_BITS + 1;

	logic [MAG_W-1:0]                sine_rom [SINE_N+1];
	logic [SINE_TABLE_ADDR_BITS-1:0] sine_idx;
	logic [ADDR_W-1:0]               rom_addr;
	logic [MAG_W-1:0]                rom_s2;
	logic signed [19:0]              u_ext;
	logic signed [19:0]              lin_shape;
	logic signed [SHAPE_W-1:0]       shape_val;
	logic                            lin_neg;
	logic [SHAPE_W-1:0]              lin_abs;
	logic                            is_sine_s2;
	logic                            quad_neg_s2;
	logic [MAG_W-1:0]                lin_mag_s2;
	logic                            lin_neg_s2;

	// Constant quarter-wave table, entries 0..N inclusive; 13-term Taylor series in Q30
	for (genvar g = 0; g <= SINE_N; g++) begin : g_sine_rom
		localparam logic [63:0] ANGLE    = (HALF_PI_Q30 * 64'(g)) >> SINE_TABLE_ADDR_BITS;
		localparam logic [63:0] ANGLE_SQ = (ANGLE * ANGLE) >> 30;
		localparam logic [63:0] T1  = ((ANGLE * ANGLE_SQ) >> 30) / 64'd6;
		localparam logic [63:0] T2  = ((T1 * ANGLE_SQ) >> 30) / 64'd20;
		localparam logic [63:0] T3  = ((T2 * ANGLE_SQ) >> 30) / 64'd42;
		localparam logic [63:0] T4  = ((T3 * ANGLE_SQ) >> 30) / 64'd72;
		localparam logic [63:0] T5  = ((T4 * ANGLE_SQ) >> 30) / 64'd110;
		localparam logic [63:0] T6  = ((T5 * ANGLE_SQ) >> 30) / 64'd156;
		localparam logic [63:0] T7  = ((T6 * ANGLE_SQ) >> 30) / 64'd210;
		localparam logic [63:0] T8  = ((T7 * ANGLE_SQ) >> 30) / 64'd272;
		localparam logic [63:0] T9  = ((T8 * ANGLE_SQ) >> 30) / 64'd342;
		localparam logic [63:0] T10 = ((T9 * ANGLE_SQ) >> 30) / 64'd420;
		localparam logic [63:0] T11 = ((T10 * ANGLE_SQ) >> 30) / 64'd506;
		localparam logic [63:0] T12 = ((T11 * ANGLE_SQ) >> 30) / 64'd600;
		localparam longint TAYLOR = longint'(ANGLE) - longint'(T1) + longint'(T2)
			- longint'(T3) + longint'(T4) - longint'(T5) + longint'(T6)
			- longint'(T7) + longint'(T8) - longint'(T9) + longint'(T10)
			- longint'(T11) + longint'(T12);
		localparam logic [MAG_W-1:0] SINE_VAL = sine_round_q16(TAYLOR);
		assign sine_rom[g] = SINE_VAL;
	end

	assign ready_s2 = !valid_s2 || ready_s3;

	// Mirror the index in odd quadrants
	assign sine_idx = u_s1[U_W-3 -: SINE_TABLE_ADDR_BITS];
	assign rom_addr = u_s1[U_W-2] ? ({1'b1, {SINE_TABLE_ADDR_BITS{1'b0}}} - {1'b0, sine_idx})
	                              : {1'b0, sine_idx};

	// Piecewise-linear shapes in 2^-16 units
	assign u_ext = signed'({4'b0000, u_s1});

	always_comb begin
		case (waveform_mode)
			MODE_RAMP:     lin_shape = (u_ext <<< 1) - 20'sd65536;
			MODE_SAWTOOTH: lin_shape = 20'sd65536 - (u_ext <<< 1);
			MODE_SQUARE:   lin_shape = ({1'b0, u_s1} < duty_threshold) ? 20'sd65536
			                                                            : -20'sd65536;
			MODE_TRIANGLE: lin_shape = u_s1[U_W-1] ? 20'sd196608 - (u_ext <<< 2)
			                                       : (u_ext <<< 2) - 20'sd65536;
			default:       lin_shape = 20'sd0;
		endcase
	end

	// Split into sign and magnitude
	assign shape_val = lin_shape[SHAPE_W-1:0];
	assign lin_neg   = shape_val[SHAPE_W-1];
	assign lin_abs   = lin_neg ? SHAPE_W'(-shape_val) : SHAPE_W'(shape_val);

	// Read the sine ROM into stage 2
	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			rom_s2 <= sine_rom[rom_addr];
		end
	end

	// Hold stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Register the shape selection and linear result
	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			is_sine_s2  <= (waveform_mode == MODE_SINE);
			quad_neg_s2 <= u_s1[U_W-1];
			lin_mag_s2  <= lin_abs[MAG_W-1:0];
			lin_neg_s2  <= lin_neg;
		end
	end

	// Pick sine or linear shape
	always_comb begin
		if (is_sine_s2) begin
			shape_s2.neg = quad_neg_s2;
			shape_s2.mag = rom_s2;
		end else begin
			shape_s2.neg = lin_neg_s2;
			shape_s2.mag = lin_mag_s2;
		end
	end

endmodule

FILE: hw/rtl/mwdds_scale.sv
// Scaling stage of the tone generator: amplitude multiply, round half away from zero,
// and the output register that drives the sample channel. Depends on mwdds_pkg.
module mwdds_scale (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            valid_s2,
	input  mwdds_pkg::shape_t               shape_s2,
	output logic                            ready_s3,
	input  logic [mwdds_pkg::AMP_W-1:0]     amplitude,
	output logic                            sample_valid,
	input  logic                            sample_stall,
	output logic [mwdds_pkg::SAMPLE_W-1:0]  sample
);
	import mwdds_pkg::*;

	logic              valid_s3;
	logic              neg_s3;
	logic [PROD_W-1:0] prod_s3;
	logic              ready_out;
	logic [PROD_W-1:0] rounded;
	logic [SAMPLE_W-1:0] mag_r;

	assign ready_out = !sample_valid || !sample_stall;
	assign ready_s3  = !valid_s3 || ready_out;

	// Hold stage 3 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	// Multiply amplitude by shape magnitude
	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			prod_s3 <= PROD_W'(amplitude) * PROD_W'(shape_s2.mag);
			neg_s3  <= shape_s2.neg;
		end
	end

	// Round the magnitude to the nearest unit, ties away from zero
	assign rounded = prod_s3 + PROD_W'(32768);
	assign mag_r   = rounded[PROD_W-1 -: SAMPLE_W];

	// Hold the output transaction until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else if (ready_out) begin
			sample_valid <= valid_s3;
		end
	end

	// Apply the sign
	always_ff @(posedge clk) begin
		if (ready_out && valid_s3) begin
			sample <= neg_s3 ? SAMPLE_W'(-mag_r) : mag_r;
		end
	end

endmodule

FILE: hw/rtl/multi_waveform_dds_top.sv
// Multi-waveform tone generator: phase accumulator, shape stage and amplitude scaling.
// Throughput: one transaction per cycle while cmd_stall is low; a phase load yields no sample.
// The four pipeline registers (capture, sine ROM read, multiply, output) set the latency.
// Reset clears the phase to zero, all pipeline valids, and the registers to their defaults.
// Depends on mwdds_pkg, mwdds_phase, mwdds_shape and mwdds_scale.
module multi_waveform_dds_top #(
	parameter int PHASE_BITS           = 32,
	parameter int SINE_TABLE_ADDR_BITS = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mwdds_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mwdds_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              cmd_valid,
	output logic                              cmd_stall,
	input  logic                              func,
	input  logic [31:0]                       phase_value,
	output logic                              sample_valid,
	input  logic                              sample_stall,
	output logic signed [15:0]                sample
);
	import mwdds_pkg::*;

	logic [STEP_W-1:0]   phase_step_q;
	logic [MODE_W-1:0]   waveform_mode_q;
	logic [AMP_W-1:0]    amplitude_q;
	logic [DUTY_W-1:0]   duty_threshold_q;
	logic                valid_s1;
	logic [U_W-1:0]      u_s1;
	logic                ready_s2;
	logic                valid_s2;
	shape_t              shape_s2;
	logic                ready_s3;
	logic [SAMPLE_W-1:0] sample_bits;

	// Decode configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q     <= '0;
			waveform_mode_q  <= MODE_SINE;
			amplitude_q      <= '0;
			duty_threshold_q <= DUTY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PHASE_STEP: phase_step_q     <= cfg_data[STEP_W-1:0];
				CFG_WAVEFORM:   waveform_mode_q  <= cfg_data[MODE_W-1:0];
				CFG_AMPLITUDE:  amplitude_q      <= cfg_data[AMP_W-1:0];
				CFG_DUTY:       duty_threshold_q <= cfg_data[DUTY_W-1:0];
				default:        ;
			endcase
		end
	end

	mwdds_phase #(
		.PHASE_BITS(PHASE_BITS)
	) u_phase (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.func       (func),
		.phase_value(phase_value),
		.phase_step (phase_step_q),
		.valid_s1   (valid_s1),
		.u_s1       (u_s1),
		.ready_s2   (ready_s2)
	);

	mwdds_shape #(
		.SINE_TABLE_ADDR_BITS(SINE_TABLE_ADDR_BITS)
	) u_shape (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s1      (valid_s1),
		.u_s1          (u_s1),
		.ready_s2      (ready_s2),
		.waveform_mode (waveform_mode_q),
		.duty_threshold(duty_threshold_q),
		.valid_s2      (valid_s2),
		.shape_s2      (shape_s2),
		.ready_s3      (ready_s3)
	);

	mwdds_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s2    (valid_s2),
		.shape_s2    (shape_s2),
		.ready_s3    (ready_s3),
		.amplitude   (amplitude_q),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample_bits)
	);

	assign sample = signed'(sample_bits);

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for multi_waveform_dds_top: directed waveform corners, then
// random register settings with sample and phase-load traffic under random stalls.
// Depends on mwdds_pkg and the multi_waveform_dds_top RTL.
module tb;
	import mwdds_pkg::*;

	localparam int SAMPLE_LATENCY = 4;
	localparam int TABLE_BITS = 10;
	localparam int TABLE_N = 1 << TABLE_BITS;
	localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	logic func = 1'b0;
	logic [31:0] phase_value = '0;
	logic sample_valid;
	logic sample_stall = 1'b0;
	logic signed [15:0] sample;

	// Mirror of the generator state and registers
	logic [31:0] tone_phase = '0;
	logic [STEP_W-1:0] tone_step = '0;
	logic [MODE_W-1:0] tone_mode = MODE_SINE;
	logic [AMP_W-1:0] tone_amp = '0;
	logic [DUTY_W-1:0] tone_duty = DUTY_RESET;
	logic [16:0] quarter_sine [0:TABLE_N];

	logic signed [15:0] pending_samples [$];
	logic signed [15:0] wanted_sample;
	int error_count = 0;
	logic no_idle = 1'b0;

	multi_waveform_dds_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.func(func),
		.phase_value(phase_value),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Quarter-wave sine entry: Taylor series on a Q30 angle, rounded to Q16
	function automatic logic [16:0] quarter_sine_entry(input longint unsigned angle);
		longint unsigned angle_sq;
		longint unsigned term;
		longint acc;
		logic [63:0] rounded;
		angle_sq = (angle * angle) >> 30;
		term = angle;
		acc = longint'(angle);
		for (int k = 1; k <= 12; k++) begin
			term = ((term * angle_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		rounded = (64'(acc) * 64'd65536 + (64'd1 << 29)) >> 30;
		return rounded[16:0];
	endfunction

	// Shape value in units of 2^-16 for the top phase bits
	function automatic int tone_shape(input logic [15:0] u);
		logic [1:0] quad;
		int idx;
		int mag;
		int su;
		logic [16:0] lim;
		quad = u[15:14];
		idx = int'(u[13:0] >> (14 - TABLE_BITS));
		su = int'(u);
		lim = (tone_duty > 17'd65536) ? 17'd65536 : tone_duty;
		case (tone_mode)
			MODE_SINE: begin
				mag = int'(quarter_sine[quad[0] ? TABLE_N - idx : idx]);
				return quad[1] ? -mag : mag;
			end
			MODE_RAMP: return 2 * su - 65536;
			MODE_SAWTOOTH: return 65536 - 2 * su;
			MODE_SQUARE: return ({1'b0, u} < lim) ? 65536 : -65536;
			MODE_TRIANGLE: return (u < 16'd32768) ? 4 * su - 65536 : 196608 - 4 * su;
			default: return 0;
		endcase
	endfunction

	// Scale the shape by amplitude, rounding half away from zero
	function automatic logic [15:0] tone_sample(input logic [15:0] u);
		int shape;
		longint unsigned mag;
		logic [31:0] r;
		shape = tone_shape(u);
		mag = longint'(tone_amp) * longint'(shape < 0 ? -shape : shape);
		r = 32'((mag + 64'd32768) >> 16);
		return (shape < 0) ? 16'(32'h10000 - r) : r[15:0];
	endfunction

	// Advance the mirror by one accepted command transaction
	task automatic apply_command(input logic f, input logic [31:0] pv);
		if (f) begin
			tone_phase = pv;
		end else begin
			pending_samples.push_back(tone_sample(tone_phase[31:16]));
			tone_phase = tone_phase + tone_step;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			CFG_PHASE_STEP: tone_step = value;
			CFG_WAVEFORM: tone_mode = value[MODE_W-1:0];
			CFG_AMPLITUDE: tone_amp = value[AMP_W-1:0];
			CFG_DUTY: tone_duty = value[DUTY_W-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Send one command transaction; returns at the edge that accepts it
	task automatic send_cmd(input logic f, input logic [31:0] pv);
		while (!no_idle && $urandom_range(0, 99) < 13) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		func <= f;
		phase_value <= pv;
		@(negedge clk);
		while (cmd_stall) begin
			@(negedge clk);
		end
		@(posedge clk);
		apply_command(f, pv);
	endtask

	// Hold the sender until every sample is back, then let a load settle
	task automatic wait_for_samples();
		cmd_valid <= 1'b0;
		while (pending_samples.size() != 0) begin
			@(posedge clk);
		end
		repeat (SAMPLE_LATENCY + 4) @(posedge clk);
	endtask

	task automatic randomize_registers();
		int sel;
		logic [31:0] value;
		sel = $urandom_range(0, 4);
		value = (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFFFF_FFFF :
			(sel == 2) ? 32'($urandom_range(0, 65535)) : $urandom;
		write_reg(CFG_PHASE_STEP, value);
		sel = $urandom_range(0, 11);
		value = (sel <= 7) ? 32'(sel) : $urandom;
		write_reg(CFG_WAVEFORM, value);
		sel = $urandom_range(0, 4);
		value = (sel == 0) ? 32'd0 : (sel == 1) ? 32'd32767 :
			(sel == 2) ? 32'hFFFF_FFFF : $urandom;
		write_reg(CFG_AMPLITUDE, value);
		sel = $urandom_range(0, 6);
		case (sel)
			0: value = 32'd0;
			1: value = 32'd65536;
			2: value = 32'd65535;
			3: value = 32'($urandom_range(65537, 131071));
			4: value = $urandom;
			default: value = 32'($urandom_range(0, 65536));
		endcase
		write_reg(CFG_DUTY, value);
	endtask

	// Reset values: sine at zero amplitude gives silence
	task automatic test_reset_defaults();
		send_cmd(1'b0, $urandom);
		send_cmd(1'b0, $urandom);
		wait_for_samples();
	endtask

	// Full amplitude, step over half a cycle; each shape at the phase top and midpoint
	task automatic test_shapes();
		write_reg(CFG_AMPLITUDE, 32'd32767);
		write_reg(CFG_PHASE_STEP, 32'h8000_0001);
		for (int m = MODE_SINE; m <= MODE_TRIANGLE; m++) begin
			write_reg(CFG_WAVEFORM, 32'(m));
			send_cmd(1'b1, 32'hFFFF_FFFF);
			send_cmd(1'b0, $urandom);
			send_cmd(1'b0, $urandom);
			wait_for_samples();
		end
	endtask

	// Undefined modes give zero while the phase keeps moving; wrap from phase zero
	task automatic test_undefined_modes();
		write_reg(CFG_WAVEFORM, 32'hFFFF_FFF5);
		send_cmd(1'b0, $urandom);
		wait_for_samples();
		write_reg(CFG_WAVEFORM, 32'd7);
		send_cmd(1'b0, $urandom);
		wait_for_samples();
		write_reg(CFG_WAVEFORM, 32'(MODE_SINE));
		write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
		send_cmd(1'b1, 32'd0);
		send_cmd(1'b0, $urandom);
		send_cmd(1'b0, $urandom);
		wait_for_samples();
	endtask

	// Square with threshold at zero, at one cycle, and above one cycle
	task automatic test_duty_limits();
		write_reg(CFG_WAVEFORM, 32'(MODE_SQUARE));
		write_reg(CFG_DUTY, 32'd0);
		send_cmd(1'b1, 32'd0);
		send_cmd(1'b0, $urandom);
		wait_for_samples();
		write_reg(CFG_DUTY, 32'd65536);
		send_cmd(1'b1, 32'hFFFF_FFFF);
		send_cmd(1'b0, $urandom);
		wait_for_samples();
		write_reg(CFG_DUTY, 32'hFFFF_FFFF);
		send_cmd(1'b1, 32'hFFFF_0000);
		send_cmd(1'b0, $urandom);
		wait_for_samples();
	endtask

	// Random settings per phase, mostly samples with occasional phase loads
	task automatic test_random_mix(input int n_phases, input int per_phase);
		for (int p = 0; p < n_phases; p++) begin
			wait_for_samples();
			randomize_registers();
			for (int i = 0; i < per_phase; i++) begin
				if ($urandom_range(0, 99) == 0) begin
					wait_for_samples();
				end
				send_cmd($urandom_range(0, 4) == 0, $urandom);
			end
		end
		wait_for_samples();
	endtask

	// Long stretch with both sides always ready
	task automatic test_back_to_back();
		no_idle = 1'b1;
		randomize_registers();
		for (int i = 0; i < 200; i++) begin
			send_cmd($urandom_range(0, 4) == 0, $urandom);
		end
		wait_for_samples();
		no_idle = 1'b0;
	endtask

	// Random backpressure on the sample channel
	always @(posedge clk) begin
		sample_stall <= !no_idle && ($urandom_range(0, 99) < 13);
	end

	// Compare each sample transaction against the oldest prediction
	always @(negedge clk) begin
		if (arst_n && sample_valid && !sample_stall) begin
			if (pending_samples.size() == 0) begin
				$display("%0t: unexpected sample: expected none, actual %0d", $time, sample);
				error_count++;
			end else begin
				wanted_sample = pending_samples.pop_front();
				if (sample !== wanted_sample) begin
					$display("%0t: sample mismatch: expected %0d, actual %0d",
						$time, wanted_sample, sample);
					error_count++;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i <= TABLE_N; i++) begin
			quarter_sine[i] = quarter_sine_entry((QUARTER_TURN_Q30 * i) / TABLE_N);
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_shapes();
		test_undefined_modes();
		test_duty_limits();
		test_random_mix(9, 148);
		test_back_to_back();
		wait_for_samples();
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/mwdds_pkg.sv
hw/rtl/mwdds_phase.sv
hw/rtl/mwdds_shape.sv
hw/rtl/mwdds_scale.sv
hw/rtl/multi_waveform_dds_top.sv
dv/tb.sv
